// ===== rtl/fhu_pkg.sv =====
// ----------------------------------------------------------------------------
// fhu_pkg: shared types and constants for the fire heat field update block
// Field geometry, transaction payload structs and fixed arithmetic constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhu_pkg;

    localparam int COLUMNS = 32;
    localparam int ROWS    = 8;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W   = 3;
    localparam int HEAT_W  = 8;
    localparam int COL_BITS = ROWS * HEAT_W;

    localparam logic [HEAT_W-1:0] SPARK_THRESHOLD_RESET = 8'd120;
    localparam logic [HEAT_W-1:0] HEAT_MAX              = 8'd255;
    localparam logic [HEAT_W-1:0] COLOR_SCALE           = 8'd240;

    // floor(x/3) == (x*683) >> 11 for every x below 2048
    localparam logic [10:0] DIV3_MUL   = 11'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef logic [ROWS-1:0][HEAT_W-1:0] heat_col_t;
    typedef logic [COL_W-1:0]            col_idx_t;
    typedef logic [ROW_W-1:0]            row_idx_t;

    typedef struct packed {
        logic       update;
        logic [4:0] column;
        logic [7:0] cool_0;
        logic [7:0] cool_1;
        logic [7:0] cool_2;
        logic [7:0] cool_3;
        logic [7:0] cool_4;
        logic [7:0] cool_5;
        logic [7:0] cool_6;
        logic [7:0] cool_7;
        logic [7:0] spark_roll;
        logic [7:0] spark_heat;
    } fhu_in_t;

    typedef struct packed {
        logic [2:0] row;
        logic [7:0] color_index;
        logic       last;
    } fhu_out_t;

    function automatic col_idx_t col_index(input logic [4:0] column);
        return COL_W'(column % COLUMNS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fhu_ram.sv =====
// ----------------------------------------------------------------------------
// fhu_ram: generic single write port ram with registered read
// One write and one read per cycle; read data holds until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/fire_heat_field_update.sv =====
// ----------------------------------------------------------------------------
// fire_heat_field_update: per-column fire heat cooling, rise, spark and render
// Flow: an accepted transaction is held in stage 1 until it loads the result
// buffer; the 8 rows follow top first, one per cycle while out_ready holds.
// Stage 1 takes a new column while rows stream; it waits for the last row.
// Reset: all heat cells read as zero (per-column valid bits), spark threshold
// is 120, pipeline and result buffer empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fire_heat_field_update
    import fhu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fhu_in_t    in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output fhu_out_t   out_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic [HEAT_W-1:0] threshold_reg;

    // stage 1: item waiting on / holding the column read
    logic               s1_valid_reg;
    fhu_in_t            s1_item_reg;
    col_idx_t           s1_col_reg;
    logic               s1_src_valid_reg;
    logic               bypass_reg;
    heat_col_t          bypass_data_reg;

    // result buffer
    logic               out_valid_reg;
    row_idx_t           row_cnt_reg;
    heat_col_t          color_buf_reg;

    logic [COLUMNS-1:0] col_valid_reg;

    logic               in_accept;
    logic               out_last;
    logic               load_out;
    col_idx_t           in_col;
    logic               ram_wr_en;
    logic [COL_BITS-1:0] ram_rd_data;

    heat_col_t          src_heat;
    heat_col_t          cool_vec;
    heat_col_t          cooled;
    heat_col_t          risen;
    heat_col_t          new_heat;
    heat_col_t          color_next;
    logic [9:0]         rise_sum  [ROWS];
    logic [20:0]        rise_prod [ROWS];
    logic [15:0]        color_prod [ROWS];
    logic [HEAT_W:0]    spark_sum;
    logic               spark_hit;

    assign in_col    = col_index(in_data.column);
    assign out_last  = (row_cnt_reg == row_idx_t'(ROWS - 1));
    assign load_out  = s1_valid_reg && (!out_valid_reg || (out_ready && out_last));
    assign in_ready  = !s1_valid_reg || load_out;
    assign in_accept = in_valid && in_ready;
    assign ram_wr_en = load_out && s1_item_reg.update;

    fhu_ram #(
        .WIDTH (COL_BITS),
        .DEPTH (COLUMNS)
    ) u_heat_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (new_heat),
        .rd_en   (in_accept),
        .rd_addr (in_col),
        .rd_data (ram_rd_data)
    );

    // a write on the same edge as the read of the same column is forwarded
    always_comb
    begin
        if (bypass_reg)
        begin
            src_heat = bypass_data_reg;
        end
        else if (s1_src_valid_reg)
        begin
            src_heat = ram_rd_data;
        end
        else
        begin
            src_heat = '0;
        end
    end

    always_comb
    begin
        cool_vec[0] = s1_item_reg.cool_0;
        cool_vec[1] = s1_item_reg.cool_1;
        cool_vec[2] = s1_item_reg.cool_2;
        cool_vec[3] = s1_item_reg.cool_3;
        cool_vec[4] = s1_item_reg.cool_4;
        cool_vec[5] = s1_item_reg.cool_5;
        cool_vec[6] = s1_item_reg.cool_6;
        cool_vec[7] = s1_item_reg.cool_7;
    end

    always_comb
    begin
        for (int j = 0; j < ROWS; j++)
        begin
            cooled[j] = (src_heat[j] > cool_vec[j]) ? (src_heat[j] - cool_vec[j]) : '0;
        end

        // row above the bottom sees the bottom twice, so it keeps that value
        for (int j = 0; j < ROWS; j++)
        begin
            if (j < ROWS - 1)
            begin
                rise_sum[j] = {1'b0, cooled[j + 1], 1'b0}
                            + {2'b00, cooled[(j + 2 < ROWS) ? j + 2 : ROWS - 1]};
            end
            else
            begin
                rise_sum[j] = '0;
            end
            rise_prod[j] = 21'(rise_sum[j]) * 21'(DIV3_MUL);
            risen[j]     = rise_prod[j][DIV3_SHIFT +: HEAT_W];
        end

        spark_hit = s1_item_reg.spark_roll < threshold_reg;
        spark_sum = {1'b0, cooled[ROWS - 1]} + {1'b0, s1_item_reg.spark_heat};

        if (s1_item_reg.update)
        begin
            new_heat = risen;
            if (!spark_hit)
            begin
                new_heat[ROWS - 1] = cooled[ROWS - 1];
            end
            else if (spark_sum[HEAT_W])
            begin
                new_heat[ROWS - 1] = HEAT_MAX;
            end
            else
            begin
                new_heat[ROWS - 1] = spark_sum[HEAT_W-1:0];
            end
        end
        else
        begin
            new_heat = src_heat;
        end

        for (int j = 0; j < ROWS; j++)
        begin
            color_prod[j] = 16'(new_heat[j]) * 16'(COLOR_SCALE);
            color_next[j] = color_prod[j][15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SPARK_THRESHOLD_RESET;
            s1_valid_reg  <= 1'b0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            col_valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                bypass_reg   <= ram_wr_en && (s1_col_reg == in_col);
            end
            else if (load_out)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (ram_wr_en)
            begin
                col_valid_reg[s1_col_reg] <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                row_cnt_reg   <= '0;
            end
            else if (out_valid_reg && out_ready)
            begin
                if (out_last)
                begin
                    out_valid_reg <= 1'b0;
                end
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg      <= in_data;
            s1_col_reg       <= in_col;
            s1_src_valid_reg <= col_valid_reg[in_col];
            bypass_data_reg  <= new_heat;
        end
        if (load_out)
        begin
            color_buf_reg <= color_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_data.row         = 3'(row_cnt_reg);
    assign out_data.color_index = color_buf_reg[row_cnt_reg];
    assign out_data.last        = out_last;

    a_wr_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (s1_valid_reg && load_out))
        else $error("heat write without a stage 1 item moving out");

    a_bypass_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bypass_reg) |-> $past(ram_wr_en))
        else $error("forwarding flagged without a preceding write");

    a_load_restarts_rows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && (row_cnt_reg == '0)))
        else $error("result buffer did not restart at the top row");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.color_index <= 8'd239))
        else $error("color index out of range");

endmodule

`default_nettype wire
